[hdl/drive_command_actuator_controller_defines.svh]
// ----------------------------------------------------------------------------
// drive command actuator controller assertion macros
// shared property forms, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef DRIVE_COMMAND_ACTUATOR_CONTROLLER_DEFINES_SVH
`define DRIVE_COMMAND_ACTUATOR_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define DCAC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCAC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dcac_pkg.sv]
// ----------------------------------------------------------------------------
// dcac_pkg
// shared widths, register codes, reset values and types of the controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcac_pkg;

  localparam int DATA_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int DELAY_W   = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_GAIN       = 3'd0,
    REG_ACCEL_LIMIT      = 3'd1,
    REG_DECEL_VALUE      = 3'd2,
    REG_STEER_RATE_LIMIT = 3'd3,
    REG_STEER_DEADBAND   = 3'd4,
    REG_DELAY_TICKS      = 3'd5
  } cfg_reg_t;

  localparam logic [DATA_W-1:0]  RST_SPEED_GAIN       = 16'd256;
  localparam logic [LIMIT_W-1:0] RST_ACCEL_LIMIT      = 15'd2048;
  localparam logic [LIMIT_W-1:0] RST_DECEL_VALUE      = 15'd2048;
  localparam logic [LIMIT_W-1:0] RST_STEER_RATE_LIMIT = 15'd819;
  localparam logic [LIMIT_W-1:0] RST_STEER_DEADBAND   = 15'd0;
  localparam logic [DELAY_W-1:0] RST_DELAY_TICKS      = 7'd0;

  typedef logic signed [DATA_W-1:0] q88_t;

  // write side of the steering delay line, one per accepted item
  typedef struct packed {
    logic wr_en;
    q88_t wr_data;
  } dl_wr_t;

endpackage

`default_nettype wire

[hdl/dcac_delay_line.sv]
// ----------------------------------------------------------------------------
// dcac_delay_line
// steering command history in a one-port-write, registered-read memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "drive_command_actuator_controller_defines.svh"

module dcac_delay_line #(
  parameter int MAX_DELAY = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dcac_pkg::dl_wr_t             wr,
  input  wire logic [dcac_pkg::DELAY_W-1:0] delay_ticks,
  output dcac_pkg::q88_t                    delayed
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int FW = $clog2(MAX_DELAY + 1);
  localparam int CW = (FW > dcac_pkg::DELAY_W) ? FW : dcac_pkg::DELAY_W;
  localparam int SW = CW + 1;

  dcac_pkg::q88_t mem [MAX_DELAY];

  logic [AW-1:0]  ptr;
  logic [FW-1:0]  fill;
  logic [CW-1:0]  d_ext;
  logic [CW-1:0]  d_sat;
  logic [SW-1:0]  ptr_w;
  logic [SW-1:0]  d_w;
  logic [SW-1:0]  raddr_w;
  logic [AW-1:0]  raddr;
  logic           raddr_ok;

  dcac_pkg::q88_t rd_raw;
  logic           rd_ok;
  logic           bypass;
  dcac_pkg::q88_t byp_data;

  always_comb begin
    d_ext = CW'(delay_ticks);
    d_sat = (d_ext > CW'(MAX_DELAY)) ? CW'(MAX_DELAY) : d_ext;
    ptr_w = SW'(ptr);
    d_w   = SW'(d_sat);
    // step back d entries around the ring
    if (ptr_w >= d_w) begin
      raddr_w = ptr_w - d_w;
    end else begin
      raddr_w = ptr_w + SW'(MAX_DELAY) - d_w;
    end
    raddr    = raddr_w[AW-1:0];
    // entries are filled in order from zero, so the fill count marks what was written
    raddr_ok = (FW'(raddr) < fill);
  end

  // read-first: a full-length delay reads the entry before it is overwritten
  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[ptr] <= wr.wr_data;
      rd_raw   <= mem[raddr];
      byp_data <= wr.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      fill   <= '0;
      rd_ok  <= 1'b0;
      bypass <= 1'b0;
    end else if (wr.wr_en) begin
      ptr    <= (ptr == AW'(MAX_DELAY - 1)) ? '0 : ptr + 1'b1;
      fill   <= (fill == FW'(MAX_DELAY)) ? fill : fill + 1'b1;
      rd_ok  <= raddr_ok;
      bypass <= (d_sat == '0);
    end
  end

  assign delayed = bypass ? byp_data : (rd_ok ? rd_raw : '0);

  logic fill_open;

  assign fill_open = (fill != FW'(MAX_DELAY));

  `DCAC_ASSERT_IMP(a_ptr_range, 1'b1, FW'(ptr) < FW'(MAX_DELAY), "write pointer past the line")
  `DCAC_ASSERT_IMP(a_fill_range, 1'b1, fill <= FW'(MAX_DELAY), "fill count past the line")
  `DCAC_ASSERT_NXT(a_fill_grows, wr.wr_en && fill_open, fill == $past(fill) + 1'b1, "fill stalled")

endmodule

`default_nettype wire

[hdl/drive_command_actuator_controller.sv]
// ----------------------------------------------------------------------------
// drive_command_actuator_controller
// acceleration and steering rate commands from commanded and measured motion
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless a held result stalls the pipeline, and
// returns it through the stage 1 and output registers; the rate is set by the
// steering delay memory, which is written and read once for every item. The
// speed gain product is registered before clamping. Reset needs no clearing
// pass: a fill count makes history from before reset read as zero, so items
// are accepted from the first cycle after reset; nothing is accepted while
// rst is high. Configuration is written through cfg_valid/cfg_index/cfg_data,
// which is ready whenever rst is low; write it only while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "drive_command_actuator_controller_defines.svh"

module drive_command_actuator_controller #(
  parameter int MAX_DELAY = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dcac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dcac_pkg::DATA_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [15:0]             target_speed,
  input  wire logic signed [15:0]             target_steer,
  input  wire logic signed [15:0]             measured_speed,
  input  wire logic signed [15:0]             measured_steer,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [15:0]                  accel_out,
  output logic signed [15:0]                  steer_rate_out
);

  // configuration registers
  logic [dcac_pkg::DATA_W-1:0]  speed_gain;
  logic [dcac_pkg::LIMIT_W-1:0] accel_limit;
  logic [dcac_pkg::LIMIT_W-1:0] decel_value;
  logic [dcac_pkg::LIMIT_W-1:0] steer_rate_limit;
  logic [dcac_pkg::LIMIT_W-1:0] steer_deadband;
  logic [dcac_pkg::DELAY_W-1:0] delay_ticks;

  logic cfg_we;

  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain       <= dcac_pkg::RST_SPEED_GAIN;
      accel_limit      <= dcac_pkg::RST_ACCEL_LIMIT;
      decel_value      <= dcac_pkg::RST_DECEL_VALUE;
      steer_rate_limit <= dcac_pkg::RST_STEER_RATE_LIMIT;
      steer_deadband   <= dcac_pkg::RST_STEER_DEADBAND;
      delay_ticks      <= dcac_pkg::RST_DELAY_TICKS;
    end else if (cfg_we) begin
      unique case (dcac_pkg::cfg_reg_t'(cfg_index))
        dcac_pkg::REG_SPEED_GAIN:       speed_gain       <= cfg_data;
        dcac_pkg::REG_ACCEL_LIMIT:      accel_limit      <= cfg_data[dcac_pkg::LIMIT_W-1:0];
        dcac_pkg::REG_DECEL_VALUE:      decel_value      <= cfg_data[dcac_pkg::LIMIT_W-1:0];
        dcac_pkg::REG_STEER_RATE_LIMIT: steer_rate_limit <= cfg_data[dcac_pkg::LIMIT_W-1:0];
        dcac_pkg::REG_STEER_DEADBAND:   steer_deadband   <= cfg_data[dcac_pkg::LIMIT_W-1:0];
        dcac_pkg::REG_DELAY_TICKS:      delay_ticks      <= cfg_data[dcac_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid;
  logic s1_adv;
  logic accept;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stage 0: speed error and gain product
  logic signed [16:0] dv;
  logic signed [32:0] prod;

  assign dv   = {target_speed[15], target_speed} - {measured_speed[15], measured_speed};
  assign prod = $signed({1'b0, speed_gain}) * dv;

  logic signed [32:0] s1_prod;
  logic               s1_mspd_pos;
  logic               s1_dv_pos;
  dcac_pkg::q88_t     s1_mstr;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod     <= prod;
      s1_mspd_pos <= !measured_speed[15] && (measured_speed != '0);
      s1_dv_pos   <= !dv[16] && (dv != '0);
      s1_mstr     <= measured_steer;
    end
  end

  dcac_pkg::dl_wr_t dl_wr;
  dcac_pkg::q88_t   s1_delayed;

  assign dl_wr.wr_en   = accept;
  assign dl_wr.wr_data = target_steer;

  dcac_delay_line #(
    .MAX_DELAY (MAX_DELAY)
  ) u_delay (
    .clk         (clk),
    .rst         (rst),
    .wr          (dl_wr),
    .delay_ticks (delay_ticks),
    .delayed     (s1_delayed)
  );

  // stage 1: floor shift, clamp, select; steering sign with deadband
  logic signed [24:0] q;
  logic signed [24:0] lim;
  logic signed [24:0] q_clamp;
  dcac_pkg::q88_t     prop;
  dcac_pkg::q88_t     decel_pos;
  dcac_pkg::q88_t     accel_next;
  logic signed [16:0] err;
  logic        [16:0] mag;
  dcac_pkg::q88_t     rate_pos;
  dcac_pkg::q88_t     steer_rate_next;

  always_comb begin
    q   = s1_prod[32:8];
    lim = 25'(accel_limit);
    if (q > lim) begin
      q_clamp = lim;
    end else if (q < -lim) begin
      q_clamp = -lim;
    end else begin
      q_clamp = q;
    end
    prop      = q_clamp[15:0];
    decel_pos = {1'b0, decel_value};
    if (s1_mspd_pos) begin
      accel_next = s1_dv_pos ? prop : -decel_pos;
    end else begin
      accel_next = s1_dv_pos ? decel_pos : prop;
    end

    err      = {s1_delayed[15], s1_delayed} - {s1_mstr[15], s1_mstr};
    mag      = err[16] ? 17'(-err) : 17'(err);
    rate_pos = {1'b0, steer_rate_limit};
    if (mag > 17'(steer_deadband)) begin
      steer_rate_next = err[16] ? -rate_pos : rate_pos;
    end else begin
      steer_rate_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      accel_out      <= accel_next;
      steer_rate_out <= steer_rate_next;
    end
  end

  logic signed [16:0] acc_w;
  logic signed [16:0] alim_w;
  logic signed [16:0] dec_w;
  logic signed [16:0] rlim_w;
  logic signed [16:0] rate_w;
  logic               acc_ok;
  logic               rate_ok;

  assign acc_w   = {accel_out[15], accel_out};
  assign alim_w  = {2'b00, accel_limit};
  assign dec_w   = {2'b00, decel_value};
  assign rlim_w  = {2'b00, steer_rate_limit};
  assign rate_w  = {steer_rate_out[15], steer_rate_out};
  assign acc_ok  = (acc_w <= alim_w && acc_w >= -alim_w)
                   || acc_w == dec_w || acc_w == -dec_w;
  assign rate_ok = rate_w == '0 || rate_w == rlim_w || rate_w == -rlim_w;

  `DCAC_ASSERT_NXT(a_s1_not_lost, s1_valid && !out_valid, out_valid, "stage 1 item stuck")
  `DCAC_ASSERT_IMP(a_accel_range, out_valid, acc_ok, "acceleration outside its limits")
  `DCAC_ASSERT_IMP(a_rate_levels, out_valid, rate_ok, "steering rate not one of three levels")

endmodule

`default_nettype wire

[test/drive_command_actuator_controller_chk.sv]
// ----------------------------------------------------------------------------
// drive_command_actuator_controller_chk
// watches the config, item and result channels of the drive command actuator
// controller, keeps its own copy of the registers and the steering history,
// predicts acceleration and steering rate for each accepted item and compares
// every returned result, in order, against the oldest open prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_command_actuator_controller_chk #(
  parameter int MAX_DELAY = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [dcac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dcac_pkg::DATA_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic signed [15:0]             target_speed,
  input  wire logic signed [15:0]             target_steer,
  input  wire logic signed [15:0]             measured_speed,
  input  wire logic signed [15:0]             measured_steer,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic signed [15:0]             accel_out,
  input  wire logic signed [15:0]             steer_rate_out,
  output int                                  fail_count,
  output int                                  outstanding
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    dcac_pkg::q88_t accel;
    dcac_pkg::q88_t steer_rate;
  } cmd_pair_t;

  logic [dcac_pkg::DATA_W-1:0]  gain;
  logic [dcac_pkg::LIMIT_W-1:0] accel_lim;
  logic [dcac_pkg::LIMIT_W-1:0] decel_mag;
  logic [dcac_pkg::LIMIT_W-1:0] rate_mag;
  logic [dcac_pkg::LIMIT_W-1:0] deadband;
  logic [dcac_pkg::DELAY_W-1:0] delay_len;

  dcac_pkg::q88_t steer_hist [MAX_DELAY];
  int             hist_wr;
  cmd_pair_t      expected_cmds [$];
  int             reported;

  // one control tick: also stores the commanded steering into the history
  function automatic cmd_pair_t control_tick(input dcac_pkg::q88_t tgt_spd,
                                             input dcac_pkg::q88_t tgt_str,
                                             input dcac_pkg::q88_t meas_spd,
                                             input dcac_pkg::q88_t meas_str);
    longint    speed_err;
    longint    prop;
    longint    lim;
    longint    accel;
    longint    cmd_str;
    longint    str_err;
    longint    err_mag;
    longint    rate;
    int        lag;
    cmd_pair_t res;
    speed_err = longint'(tgt_spd) - longint'(meas_spd);
    lim = longint'(accel_lim);
    // arithmetic shift rounds toward minus infinity
    prop = (longint'(gain) * speed_err) >>> 8;
    if (prop > lim) prop = lim;
    if (prop < -lim) prop = -lim;
    if (meas_spd > 0) begin
      accel = (speed_err > 0) ? prop : -longint'(decel_mag);
    end else begin
      accel = (speed_err > 0) ? longint'(decel_mag) : prop;
    end

    lag = (delay_len > MAX_DELAY) ? MAX_DELAY : int'(delay_len);
    if (lag == 0) begin
      cmd_str = tgt_str;
    end else begin
      cmd_str = steer_hist[(hist_wr + MAX_DELAY - lag) % MAX_DELAY];
    end
    steer_hist[hist_wr] = tgt_str;
    hist_wr = (hist_wr + 1) % MAX_DELAY;

    str_err = cmd_str - longint'(meas_str);
    err_mag = (str_err < 0) ? -str_err : str_err;
    if (err_mag > longint'(deadband)) begin
      rate = (str_err > 0) ? longint'(rate_mag) : -longint'(rate_mag);
    end else begin
      rate = 0;
    end
    res.accel = accel[15:0];
    res.steer_rate = rate[15:0];
    return res;
  endfunction

  always @(posedge clk) begin
    cmd_pair_t got;
    cmd_pair_t want;
    if (rst) begin
      gain      = dcac_pkg::RST_SPEED_GAIN;
      accel_lim = dcac_pkg::RST_ACCEL_LIMIT;
      decel_mag = dcac_pkg::RST_DECEL_VALUE;
      rate_mag  = dcac_pkg::RST_STEER_RATE_LIMIT;
      deadband  = dcac_pkg::RST_STEER_DEADBAND;
      delay_len = dcac_pkg::RST_DELAY_TICKS;
      foreach (steer_hist[i]) steer_hist[i] = '0;
      hist_wr = 0;
      expected_cmds.delete();
      reported = 0;
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (dcac_pkg::cfg_reg_t'(cfg_index))
          dcac_pkg::REG_SPEED_GAIN:       gain      = cfg_data;
          dcac_pkg::REG_ACCEL_LIMIT:      accel_lim = cfg_data[dcac_pkg::LIMIT_W-1:0];
          dcac_pkg::REG_DECEL_VALUE:      decel_mag = cfg_data[dcac_pkg::LIMIT_W-1:0];
          dcac_pkg::REG_STEER_RATE_LIMIT: rate_mag  = cfg_data[dcac_pkg::LIMIT_W-1:0];
          dcac_pkg::REG_STEER_DEADBAND:   deadband  = cfg_data[dcac_pkg::LIMIT_W-1:0];
          dcac_pkg::REG_DELAY_TICKS:      delay_len = cfg_data[dcac_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        expected_cmds.insert(expected_cmds.size(),
                             control_tick(target_speed, target_steer,
                                          measured_speed, measured_steer));
      end

      if (out_valid && out_ready) begin
        got.accel = accel_out;
        got.steer_rate = steer_rate_out;
        if (expected_cmds.size() == 0) begin
          fail_count++;
          if (reported < MAX_REPORTS) begin
            $display("%0t: result with no open item: accel %0d, steer rate %0d",
                     $realtime, got.accel, got.steer_rate);
          end
          reported++;
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            fail_count++;
            if (reported < MAX_REPORTS) begin
              $display("%0t: mismatch: accel exp %0d got %0d, steer rate exp %0d got %0d",
                       $realtime, want.accel, got.accel, want.steer_rate, got.steer_rate);
            end
            reported++;
          end
        end
      end
      outstanding <= expected_cmds.size();
    end
  end

endmodule

[test/tb_drive_command_actuator_controller.sv]
// ----------------------------------------------------------------------------
// tb_drive_command_actuator_controller
// stimulus and verdict for the drive command actuator controller: a short
// directed set over speed/steer extremes and register extremes, then random
// register settings with bursty items and a stalling receiver, including one
// long receiver hold-off; checking lives in the checker module
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_drive_command_actuator_controller;

  localparam int          RESET_CYCLES    = 9;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          RAND_PHASES     = 8;
  localparam int          ITEMS_PER_PHASE = 50;
  localparam int unsigned CYCLE_LIMIT     = 500000;

  // indexes with no register behind them
  localparam logic [dcac_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [dcac_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef enum int {RX_FREE, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic [dcac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dcac_pkg::DATA_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic signed [15:0]             target_speed = '0;
  logic signed [15:0]             target_steer = '0;
  logic signed [15:0]             measured_speed = '0;
  logic signed [15:0]             measured_steer = '0;
  logic                           out_ready = 1'b0;
  wire logic                      cfg_ready;
  wire logic                      in_ready;
  wire logic                      out_valid;
  wire logic signed [15:0]        accel_out;
  wire logic signed [15:0]        steer_rate_out;
  int                             fail_count;
  int                             outstanding;

  int                             burst_left = 0;
  int                             gap_len = 0;
  logic                           hold_req = 1'b0;
  logic [dcac_pkg::LIMIT_W-1:0]   cur_deadband = dcac_pkg::RST_STEER_DEADBAND;
  logic [dcac_pkg::DELAY_W-1:0]   cur_delay = dcac_pkg::RST_DELAY_TICKS;
  int unsigned                    cycle_cnt = 0;

  drive_command_actuator_controller i_dut (.*);

  drive_command_actuator_controller_chk i_chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall pattern from four modes, one long hold on request
  initial begin : receiver
    rx_mode_t rx_mode;
    int       mode_left;
    int       tick;
    logic     hold_done;
    rx_mode = RX_FREE;
    mode_left = 0;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        tick++;
        case (rx_mode)
          RX_FREE:  out_ready <= 1'b1;
          RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
          RX_COMB:  out_ready <= (tick % 4) != 3;
          default:  out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [dcac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dcac_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper bits beyond each limit and delay field are filled with junk, the block must drop them
  task automatic program_regs(input logic [dcac_pkg::DATA_W-1:0] gain,
                              input logic [dcac_pkg::LIMIT_W-1:0] alim,
                              input logic [dcac_pkg::LIMIT_W-1:0] dec,
                              input logic [dcac_pkg::LIMIT_W-1:0] rlim,
                              input logic [dcac_pkg::LIMIT_W-1:0] dband,
                              input logic [dcac_pkg::DELAY_W-1:0] dly);
    write_reg(dcac_pkg::REG_SPEED_GAIN, gain);
    write_reg(dcac_pkg::REG_ACCEL_LIMIT, {1'($urandom), alim});
    write_reg(dcac_pkg::REG_DECEL_VALUE, {1'($urandom), dec});
    write_reg(dcac_pkg::REG_STEER_RATE_LIMIT, {1'($urandom), rlim});
    write_reg(dcac_pkg::REG_STEER_DEADBAND, {1'($urandom), dband});
    write_reg(IDX_SPARE_LO, 16'($urandom));
    write_reg(dcac_pkg::REG_DELAY_TICKS, {9'($urandom), dly});
    write_reg(IDX_SPARE_HI, 16'($urandom));
    cfg_valid <= 1'b0;
    cur_deadband = dband;
    cur_delay = dly;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves valid high so a burst runs back to back
  task automatic send_item(input dcac_pkg::q88_t spd_cmd, input dcac_pkg::q88_t str_cmd,
                           input dcac_pkg::q88_t spd_meas, input dcac_pkg::q88_t str_meas);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    target_speed   <= spd_cmd;
    target_steer   <= str_cmd;
    measured_speed <= spd_meas;
    measured_steer <= str_meas;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  function automatic dcac_pkg::q88_t pick_q88();
    case ($urandom_range(0, 3))
      0:       return dcac_pkg::q88_t'($urandom);
      1:       return dcac_pkg::q88_t'($urandom_range(0, 1024) - 512);
      2:       return dcac_pkg::q88_t'($urandom_range(0, 8) - 4);
      default: return dcac_pkg::q88_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [dcac_pkg::DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'd256;
      3:       return 16'($urandom_range(0, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [dcac_pkg::LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 15'h7FFF;
      2:       return 15'($urandom_range(0, 1024));
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic logic [dcac_pkg::LIMIT_W-1:0] pick_deadband();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 15'h7FFF;
      2:       return 15'($urandom);
      default: return 15'($urandom_range(0, 16));
    endcase
  endfunction

  function automatic logic [dcac_pkg::DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(0, 64));
    endcase
  endfunction

  task automatic send_random();
    dcac_pkg::q88_t spd_cmd;
    dcac_pkg::q88_t str_cmd;
    dcac_pkg::q88_t spd_meas;
    dcac_pkg::q88_t str_meas;
    logic [15:0]    band_off;
    spd_cmd  = pick_q88();
    str_cmd  = pick_q88();
    spd_meas = pick_q88();
    str_meas = pick_q88();
    if ($urandom_range(0, 7) == 0) spd_cmd = spd_meas;
    // with no delay the steering error is known here: aim at the deadband edge
    if (cur_delay == 0 && $urandom_range(0, 3) == 0) begin
      band_off = 16'(cur_deadband) + 16'($urandom_range(0, 4)) - 16'd2;
      str_meas = $urandom_range(0, 1) ? str_cmd - band_off : str_cmd + band_off;
    end
    send_item(spd_cmd, str_cmd, spd_meas, str_meas);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // register defaults: every branch of the speed rule, speed and steer extremes
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd1024, 16'sd256, 16'sd256, 16'sd0);
    send_item(16'sd256, -16'sd256, 16'sd1024, 16'sd0);
    send_item(16'sd256, 16'sd0, 16'sd256, 16'sd0);
    send_item(16'sd512, 16'sd100, -16'sd256, 16'sd100);
    send_item(-16'sd4096, -16'sd100, -16'sd256, 16'sd0);
    send_item(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_item(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_item(16'sd32767, 16'sd1, 16'sd1, 16'sd0);
    send_item(-16'sd32768, 16'sd0, 16'sd0, 16'sd1);
    send_item(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
    send_item(16'sd0, 16'sd0, -16'sd1, -16'sd1);
    in_valid <= 1'b0;
    wait_idle();

    // register maxima but a deadband of one, full delay reads entries not written since reset
    program_regs(16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd1, 7'd64);
    send_item(-16'sd1, 16'sd1, 16'sd0, 16'sd0);
    send_item(16'sd257, 16'sd2, 16'sd256, 16'sd0);
    send_item(16'sd32767, 16'sd0, 16'sd1, 16'sd2);
    send_item(-16'sd32768, 16'sd0, -16'sd1, -16'sd1);
    send_item(16'sd100, -16'sd5, 16'sd100, -16'sd2);
    send_item(16'sd0, 16'sd7, 16'sd0, 16'sd0);
    in_valid <= 1'b0;
    wait_idle();

    // all zero, delay past the end of the line
    program_regs('0, '0, '0, '0, '0, 7'd100);
    send_item(16'sd1000, 16'sd500, 16'sd10, -16'sd500);
    send_item(-16'sd1000, -16'sd1, -16'sd10, 16'sd0);
    send_item(16'sd5, 16'sd0, -16'sd5, 16'sd3);
    in_valid <= 1'b0;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      program_regs(pick_gain(), pick_limit(), pick_limit(), pick_limit(),
                   pick_deadband(), pick_delay());
      // receiver backs off for a long while, input side must fill and stall
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
      in_valid <= 1'b0;
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[drive_command_actuator_controller.f]
+incdir+hdl
hdl/dcac_pkg.sv
hdl/dcac_delay_line.sv
hdl/drive_command_actuator_controller.sv
test/drive_command_actuator_controller_chk.sv
test/tb_drive_command_actuator_controller.sv
